@@ hw/rtl/pkgrd_pkg.sv @@
// Shared types and constants for the packed glyph run-length decoder.
package pkgrd_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CSR_FLAG   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [3:0] DYN_RAW    = 4'd14;
   localparam logic [3:0] NYB_REPEAT = 4'd14;
   localparam logic [3:0] NYB_ONCE   = 4'd15;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       glyph_start;
   } pkgrd_word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RAW,
      ST_NYB,
      ST_PAINT,
      ST_NEXT,
      ST_FIN,
      ST_REP
   } pkgrd_state_type;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_ZEROS,
      PH_DIGITS,
      PH_SECOND
   } pkgrd_phase_type;

endpackage

@@ hw/rtl/pkgrd_front.sv @@
// Front end: accepts packed words and queues them for the decode engine.
module pkgrd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_glyph_start,
   output logic                     word_valid,
   output pkgrd_pkg::pkgrd_word_type word,
   input  logic                     word_pop
);
   import pkgrd_pkg::*;

   pkgrd_word_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]         cnt_ff, cnt_in;
   logic                    push, pop;

   assign req_stall  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign word_valid = (cnt_ff != '0);
   assign word       = mem_ff[rd_ff];
   assign push       = req_valid && !req_stall;
   assign pop        = word_pop && word_valid;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= '{data_byte: req_data_byte, glyph_start: req_glyph_start};
      end
   end

endmodule

@@ hw/rtl/pkgrd_back.sv @@
// Back end: nybble parser, run painter and row emitter with output register.
module pkgrd_back #(
   parameter int MAX_WIDTH  = pkgrd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = pkgrd_pkg::DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     word_valid,
   input  pkgrd_pkg::pkgrd_word_type word,
   output logic                     word_pop,
   input  logic [7:0]               flag_byte,
   input  logic [6:0]               glyph_width,
   input  logic [6:0]               glyph_height,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [5:0]               rsp_row_index,
   output logic [63:0]              rsp_row_pixels,
   output logic                     rsp_last_row
);
   import pkgrd_pkg::*;

   localparam int HCAP = (MAX_HEIGHT > 64) ? 64 : MAX_HEIGHT;
   localparam logic [6:0] WCAP = 7'(MAX_WIDTH);
   localparam logic [6:0] HLIM = 7'(HCAP);

   pkgrd_state_type state_ff, state_in, ret_ff, ret_in;
   pkgrd_phase_type phase_ff, phase_in;
   logic [7:0]  byte_ff, byte_in;
   logic        raw_ff, raw_in, sel_ff, sel_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] cur_ff, cur_in, prev_ff, prev_in;
   logic [6:0]  col_ff, col_in, rows_ff, rows_in, rep_ff, rep_in;
   logic [15:0] run_ff, run_in, acc_ff, acc_in;
   logic        colour_ff, colour_in, done_ff, done_in;
   logic [3:0]  dc_ff, dc_in;
   logic [7:0]  nir_ff, nir_in;
   logic        out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [5:0]  out_index_ff, out_index_in;
   logic [63:0] out_pix_ff, out_pix_in;

   logic [6:0]  eff_w, eff_h, room, chunk;
   logic [3:0]  f, nyb;
   logic        slot_free, bit_val, have_num;
   logic [19:0] acc_shift;
   logic [15:0] acc_sat, num;
   logic [3:0]  dc_dec;
   logic signed [19:0] v_dig;
   logic [20:0] v_sec;

   function automatic logic [63:0] low_mask(input logic [6:0] n);
      logic [63:0] m;
      if (n >= 7'd64) begin
         m = '1;
      end else begin
         m = (64'd1 << n[5:0]) - 64'd1;
      end
      return m;
   endfunction

   assign eff_w = (glyph_width == 7'd0) ? 7'd1 :
                  (glyph_width > WCAP) ? WCAP : glyph_width;
   assign eff_h = (glyph_height > HLIM) ? HLIM : glyph_height;
   assign f     = flag_byte[7:4];
   assign nyb   = sel_ff ? byte_ff[3:0] : byte_ff[7:4];
   assign room  = eff_w - col_ff;
   assign chunk = (run_ff < {9'd0, room}) ? run_ff[6:0] : room;
   assign bit_val   = byte_ff[3'd7 - idx_ff];
   assign slot_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_row_index  = out_index_ff;
   assign rsp_row_pixels = out_pix_ff;
   assign rsp_last_row   = out_last_ff;
   assign word_pop       = (state_ff == ST_IDLE) && word_valid;

   always_comb begin
      acc_shift = {acc_ff, nyb};
      acc_sat   = (acc_shift > 20'd65535) ? 16'hFFFF : acc_shift[15:0];
      dc_dec    = (dc_ff != 4'd0) ? dc_ff - 4'd1 : 4'd0;
      v_dig     = $signed({4'd0, acc_sat}) + 20'sd193 - $signed({16'd0, f}) * 20'sd15;
      v_sec     = {1'b0, acc_shift} + {17'd0, f} + 21'd1;
      have_num  = 1'b0;
      num       = '0;
      case (phase_ff)
         PH_DIGITS: begin
            have_num = (dc_dec == 4'd0);
            if (v_dig < 0) begin
               num = '0;
            end else if (v_dig > 20'sd65535) begin
               num = 16'hFFFF;
            end else begin
               num = v_dig[15:0];
            end
         end
         PH_SECOND: begin
            have_num = 1'b1;
            num = (v_sec > 21'd65535) ? 16'hFFFF : v_sec[15:0];
         end
         PH_FIRST: begin
            have_num = (nyb != 4'd0) && (nyb <= f);
            num = {12'd0, nyb};
         end
         default: begin
            have_num = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      case (state_ff)
         ST_IDLE: begin
            if (word_valid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rows_ff >= eff_h || done_ff) begin
               state_in = ST_IDLE;
            end else begin
               state_in = raw_ff ? ST_RAW : ST_NYB;
            end
         end
         ST_RAW: begin
            if (done_ff) begin
               state_in = ST_IDLE;
            end else if (col_ff >= eff_w) begin
               state_in = ST_FIN;
               ret_in   = ST_RAW;
            end else if (col_ff + 7'd1 >= eff_w) begin
               state_in = ST_FIN;
               ret_in   = ST_NEXT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (raw_ff) begin
               state_in = (idx_ff == 3'd7) ? ST_IDLE : ST_RAW;
            end else begin
               state_in = sel_ff ? ST_IDLE : ST_NYB;
            end
         end
         ST_NYB: begin
            if (done_ff) begin
               state_in = ST_IDLE;
            end else if (have_num && nir_ff == 8'd0) begin
               state_in = ST_PAINT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_PAINT: begin
            if (done_ff) begin
               state_in = ST_NEXT;
            end else if (col_ff >= eff_w) begin
               state_in = ST_FIN;
               ret_in   = ST_PAINT;
            end else if (run_ff == 16'd0) begin
               state_in = ST_NEXT;
            end
         end
         ST_FIN: begin
            if (slot_free) state_in = ST_REP;
         end
         ST_REP: begin
            if (!(rep_ff != 7'd0 && rows_ff < eff_h)) state_in = ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      byte_in      = byte_ff;
      raw_in       = raw_ff;
      sel_in       = sel_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      col_in       = col_ff;
      rows_in      = rows_ff;
      rep_in       = rep_ff;
      run_in       = run_ff;
      acc_in       = acc_ff;
      colour_in    = colour_ff;
      done_in      = done_ff;
      dc_in        = dc_ff;
      nir_in       = nir_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_pix_in   = out_pix_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (word_valid) begin
               byte_in = word.data_byte;
               raw_in  = (f == DYN_RAW);
               sel_in  = 1'b0;
               idx_in  = 3'd0;
               if (word.glyph_start) begin
                  cur_in    = '0;
                  prev_in   = '0;
                  col_in    = '0;
                  rows_in   = '0;
                  run_in    = '0;
                  colour_in = ~flag_byte[3];
                  rep_in    = '0;
                  phase_in  = PH_FIRST;
                  dc_in     = '0;
                  acc_in    = '0;
                  nir_in    = '0;
                  done_in   = 1'b0;
               end
            end
         end
         ST_CHECK: begin
            if (rows_ff >= eff_h) done_in = 1'b1;
         end
         ST_RAW: begin
            if (!done_ff && col_ff < eff_w) begin
               if (!bit_val) cur_in = cur_ff | (64'd1 << col_ff[5:0]);
               col_in = col_ff + 7'd1;
            end
         end
         ST_NEXT: begin
            if (raw_ff) begin
               idx_in = idx_ff + 3'd1;
            end else begin
               sel_in = 1'b1;
            end
         end
         ST_NYB: begin
            if (!done_ff) begin
               case (phase_ff)
                  PH_ZEROS: begin
                     if (nyb == 4'd0) begin
                        if (dc_ff < 4'd15) dc_in = dc_ff + 4'd1;
                     end else begin
                        acc_in   = {12'd0, nyb};
                        phase_in = PH_DIGITS;
                     end
                  end
                  PH_DIGITS: begin
                     acc_in = acc_sat;
                     dc_in  = dc_dec;
                     if (dc_dec == 4'd0) phase_in = PH_FIRST;
                  end
                  PH_SECOND: begin
                     phase_in = PH_FIRST;
                  end
                  default: begin
                     phase_in = PH_FIRST;
                     if (nyb == 4'd0) begin
                        dc_in    = 4'd1;
                        phase_in = PH_ZEROS;
                     end else if (nyb <= f) begin
                        phase_in = PH_FIRST;
                     end else if (nyb < NYB_REPEAT) begin
                        acc_in   = {12'd0, nyb - f - 4'd1};
                        phase_in = PH_SECOND;
                     end else if (nyb == NYB_REPEAT) begin
                        if (nir_ff != 8'hFF) nir_in = nir_ff + 8'd1;
                     end else begin
                        rep_in = 7'd1;
                     end
                  end
               endcase
               if (have_num) begin
                  if (nir_ff != 8'd0) begin
                     rep_in = (num > 16'd127) ? 7'd127 : num[6:0];
                     nir_in = nir_ff - 8'd1;
                  end else begin
                     run_in    = num;
                     colour_in = ~colour_ff;
                  end
               end
            end
         end
         ST_PAINT: begin
            if (!done_ff && col_ff < eff_w && run_ff != 16'd0) begin
               if (colour_ff) begin
                  cur_in = cur_ff | (low_mask(col_ff + chunk) & ~low_mask(col_ff));
               end
               col_in = col_ff + chunk;
               run_in = run_ff - {9'd0, chunk};
            end
         end
         ST_FIN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_index_in = rows_ff[5:0];
               out_pix_in   = cur_ff;
               out_last_in  = (rows_ff + 7'd1 == eff_h);
               prev_in      = cur_ff;
               cur_in       = '0;
               col_in       = '0;
               rows_in      = rows_ff + 7'd1;
            end
         end
         ST_REP: begin
            if (rep_ff != 7'd0 && rows_ff < eff_h) begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  out_index_in = rows_ff[5:0];
                  out_pix_in   = prev_ff;
                  out_last_in  = (rows_ff + 7'd1 == eff_h);
                  rep_in       = rep_ff - 7'd1;
                  rows_in      = rows_ff + 7'd1;
               end
            end else if (rows_ff >= eff_h) begin
               done_in = 1'b1;
            end
         end
         default: begin
            done_in = done_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         raw_ff       <= 1'b0;
         sel_ff       <= 1'b0;
         idx_ff       <= '0;
         cur_ff       <= '0;
         prev_ff      <= '0;
         col_ff       <= '0;
         rows_ff      <= '0;
         rep_ff       <= '0;
         run_ff       <= '0;
         acc_ff       <= '0;
         colour_ff    <= 1'b1;
         done_ff      <= 1'b0;
         dc_ff        <= '0;
         nir_ff       <= '0;
         phase_ff     <= PH_FIRST;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         raw_ff       <= raw_in;
         sel_ff       <= sel_in;
         idx_ff       <= idx_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         col_ff       <= col_in;
         rows_ff      <= rows_in;
         rep_ff       <= rep_in;
         run_ff       <= run_in;
         acc_ff       <= acc_in;
         colour_ff    <= colour_in;
         done_ff      <= done_in;
         dc_ff        <= dc_in;
         nir_ff       <= nir_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      out_index_ff <= out_index_in;
      out_pix_ff   <= out_pix_in;
      out_last_ff  <= out_last_in;
   end

endmodule

@@ hw/rtl/pk_glyph_run_length_decoder_core.sv @@
// Top level of the packed glyph run-length decoder.
// Takes one byte of a glyph's packed raster per word and returns finished rows, one word per
// row, repeated rows included. Bytes go into a four-deep queue, so the input keeps flowing while
// the decode engine works, until the queue is full. The engine is a sequencer. A byte enters
// through the idle and check states; a packed byte is then parsed one nybble at a time and a
// raw bitmap byte one pixel bit at a time. Each run number paints its row segments and then
// closes the run. Each finished row passes the finish and repeat states, and each repeated copy
// is emitted from the repeat state. A waiting row held by rsp_stall holds the engine. Bytes after
// the last row are dropped. Configuration is taken at any time and must only change while
// the block is idle.
module pk_glyph_run_length_decoder_core #(
   parameter int MAX_WIDTH  = pkgrd_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = pkgrd_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_glyph_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_row_index,
   output logic [63:0] rsp_row_pixels,
   output logic        rsp_last_row,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import pkgrd_pkg::*;

   logic [7:0]     flag_ff;
   logic [6:0]     width_ff, height_ff;
   logic           word_valid, word_pop;
   pkgrd_word_type word;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= 8'd0;
         width_ff  <= 7'd1;
         height_ff <= 7'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FLAG:   flag_ff   <= csr_data;
            CSR_WIDTH:  width_ff  <= csr_data[6:0];
            CSR_HEIGHT: height_ff <= csr_data[6:0];
            default: begin
               flag_ff <= flag_ff;
            end
         endcase
      end
   end

   pkgrd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_glyph_start (req_glyph_start),
      .word_valid      (word_valid),
      .word            (word),
      .word_pop        (word_pop)
   );

   pkgrd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .word_valid     (word_valid),
      .word           (word),
      .word_pop       (word_pop),
      .flag_byte      (flag_ff),
      .glyph_width    (width_ff),
      .glyph_height   (height_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_row_pixels (rsp_row_pixels),
      .rsp_last_row   (rsp_last_row)
   );

endmodule
